// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CompBits     = 8;
    localparam int HueBits      = 15;
    localparam int SatBits      = 8;
    localparam int SatNumBits   = 2 * CompBits;
    localparam int HueQBits     = 12;
    localparam int HueNumBits   = CompBits + HueQBits;
    localparam int DivSteps     = HueQBits;
    localparam int SatSteps     = SatBits;
    localparam int QueueDepth   = 4;

    localparam logic [CompBits-1:0]   CompFull  = '1;
    localparam logic [HueQBits-1:0]   HueUnit   = 12'd3840;
    localparam logic [HueBits-1:0]    HueGreen  = 15'd7680;
    localparam logic [HueBits-1:0]    HueBlue   = 15'd15360;
    localparam logic signed [15:0]    HueWrap   = 16'sd23040;

    typedef enum logic [1:0] {
        SectorRed,
        SectorGreen,
        SectorBlue
    } t_sector;

    typedef struct packed {
        logic [CompBits-1:0] red;
        logic [CompBits-1:0] green;
        logic [CompBits-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HueBits-1:0]  hue;
        logic [SatBits-1:0]  saturation;
        logic [CompBits-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CompBits-1:0]   bright;
        logic [CompBits-1:0]   delta;
        logic [SatNumBits-1:0] sat_num;
        logic [HueNumBits-1:0] hue_num;
        logic                  neg;
        t_sector               sector;
        logic                  grey;
    } t_job;

    typedef struct packed {
        logic [CompBits-1:0] rem;
        logic [HueQBits-1:0] q;
    } t_hdiv;

    typedef struct packed {
        logic [CompBits-1:0] rem;
        logic [SatBits-1:0]  q;
    } t_sdiv;

    function automatic logic [HueBits-1:0] sector_base(input t_sector sec);
        logic [HueBits-1:0] base;
        unique case (sec)
            SectorRed:   base = '0;
            SectorGreen: base = HueGreen;
            SectorBlue:  base = HueBlue;
            default:     base = '0;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Pixel classification: max, min, delta, hue sector and division operands.
// ----------------------------------------------------------------------------
module rhc_front (
    input  rhc_pkg::t_pixel i_pixel,
    output rhc_pkg::t_job   o_job
);

    logic [rhc_pkg::CompBits-1:0] mx;
    logic [rhc_pkg::CompBits-1:0] mn;
    logic [rhc_pkg::CompBits:0]   num;
    logic [rhc_pkg::CompBits-1:0] mag;

    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;

        priority if (mx == i_pixel.red) begin
            o_job.sector = rhc_pkg::SectorRed;
            num = {1'b0, i_pixel.green} - {1'b0, i_pixel.blue};
        end else if (mx == i_pixel.green) begin
            o_job.sector = rhc_pkg::SectorGreen;
            num = {1'b0, i_pixel.blue} - {1'b0, i_pixel.red};
        end else begin
            o_job.sector = rhc_pkg::SectorBlue;
            num = {1'b0, i_pixel.red} - {1'b0, i_pixel.green};
        end

        mag = num[rhc_pkg::CompBits] ? rhc_pkg::CompBits'(-num) : num[rhc_pkg::CompBits-1:0];

        o_job.bright  = mx;
        o_job.delta   = mx - mn;
        o_job.neg     = num[rhc_pkg::CompBits];
        o_job.grey    = (mx == mn);
        o_job.sat_num = rhc_pkg::SatNumBits'(mx - mn) * rhc_pkg::SatNumBits'(rhc_pkg::CompFull);
        o_job.hue_num = rhc_pkg::HueNumBits'(mag) * rhc_pkg::HueNumBits'(rhc_pkg::HueUnit);
    end

endmodule

// ===== rtl/rhc_queue.sv =====
// ----------------------------------------------------------------------------
// rhc_queue
// Small transaction queue between the classification front and divider back.
// ----------------------------------------------------------------------------
module rhc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rhc_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rhc_pkg::t_job o_data
);

    localparam int PtrBits = $clog2(rhc_pkg::QueueDepth);
    localparam int CntBits = $clog2(rhc_pkg::QueueDepth + 1);

    rhc_pkg::t_job        r_mem [rhc_pkg::QueueDepth];
    logic [PtrBits-1:0]   r_wr_ptr;
    logic [PtrBits-1:0]   r_rd_ptr;
    logic [CntBits-1:0]   r_count;
    logic [CntBits-1:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + CntBits'(1);
        if (!i_push && i_pop) n_count = r_count - CntBits'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PtrBits'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + PtrBits'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_full  = (r_count == CntBits'(rhc_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/rhc_back.sv =====
// ----------------------------------------------------------------------------
// rhc_back
// Pipelined restoring dividers for hue and saturation, one quotient bit per
// stage, followed by the hue sector offset and the output register.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rhc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    output rhc_pkg::t_hsv o_hsv,
    input  logic          i_stall
);

    localparam int N = rhc_pkg::DivSteps;
    localparam int C = rhc_pkg::CompBits;

    rhc_pkg::t_job  r_job [0:N];
    rhc_pkg::t_hdiv r_hue [0:N];
    rhc_pkg::t_sdiv r_sat [0:N];
    logic [N:0]     r_vld;
    rhc_pkg::t_hdiv n_hue [1:N];
    rhc_pkg::t_sdiv n_sat [1:N];
    rhc_pkg::t_hsv  r_out;
    logic           r_out_valid;
    rhc_pkg::t_hsv  n_out;
    logic           en;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && i_valid;

    for (genvar k = 1; k <= N; k++) begin : g_stage
        always_comb begin
            logic [C:0] h_t;
            h_t = {r_hue[k-1].rem, r_job[k-1].hue_num[rhc_pkg::HueQBits-k]};
            if (h_t >= {1'b0, r_job[k-1].delta}) begin
                n_hue[k].rem = C'(h_t - {1'b0, r_job[k-1].delta});
                n_hue[k].q   = {r_hue[k-1].q[rhc_pkg::HueQBits-2:0], 1'b1};
            end else begin
                n_hue[k].rem = h_t[C-1:0];
                n_hue[k].q   = {r_hue[k-1].q[rhc_pkg::HueQBits-2:0], 1'b0};
            end
        end
        if (k <= rhc_pkg::SatSteps) begin : g_sat
            always_comb begin
                logic [C:0] s_t;
                s_t = {r_sat[k-1].rem, r_job[k-1].sat_num[rhc_pkg::SatSteps-k]};
                if (s_t >= {1'b0, r_job[k-1].bright}) begin
                    n_sat[k].rem = C'(s_t - {1'b0, r_job[k-1].bright});
                    n_sat[k].q   = {r_sat[k-1].q[rhc_pkg::SatBits-2:0], 1'b1};
                end else begin
                    n_sat[k].rem = s_t[C-1:0];
                    n_sat[k].q   = {r_sat[k-1].q[rhc_pkg::SatBits-2:0], 1'b0};
                end
            end
        end else begin : g_pass
            assign n_sat[k] = r_sat[k-1];
        end
    end

    always_comb begin
        logic signed [15:0] q_s;
        logic signed [15:0] h;
        q_s = $signed(16'(r_hue[N].q));
        h = $signed(16'(rhc_pkg::sector_base(r_job[N].sector)))
            + (r_job[N].neg ? -q_s : q_s);
        if (h < 0) h = h + rhc_pkg::HueWrap;
        n_out.brightness = r_job[N].bright;
        n_out.hue        = r_job[N].grey ? '0 : rhc_pkg::HueBits'(h);
        n_out.saturation = r_job[N].grey ? '0 : r_sat[N].q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[N-1:0], i_valid};
            r_out_valid <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0]     <= i_job;
            r_hue[0].rem <= i_job.hue_num[rhc_pkg::HueNumBits-1:rhc_pkg::HueQBits];
            r_hue[0].q   <= '0;
            r_sat[0].rem <= i_job.sat_num[rhc_pkg::SatNumBits-1:rhc_pkg::SatSteps];
            r_sat[0].q   <= '0;
            for (int k = 1; k <= N; k++) begin
                r_job[k] <= r_job[k-1];
                r_hue[k] <= n_hue[k];
                r_sat[k] <= n_sat[k];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_out;

endmodule

// ===== rtl/rgb_to_hsv_converter_top.sv =====
// an accepted pixel is written to the queue, then passes the divider stage registers and the output register
// throughput: one pixel per cycle while the output is not stalled, set by the 12-stage hue divider pipeline
// saturation division runs alongside in the first 8 of those stages
// reset clears the queue pointers and the pipeline valid bits; no clearing pass
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB to HSV pixel converter: classification front, transaction queue and
// pipelined divider back end.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rhc_pkg::t_pixel i_pixel,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rhc_pkg::t_hsv   o_hsv
);

    rhc_pkg::t_job job_in;
    rhc_pkg::t_job job_q;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    rhc_front u_front (
        .i_pixel (i_pixel),
        .o_job   (job_in)
    );

    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (job_q)
    );

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (job_q),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .o_hsv   (o_hsv),
        .i_stall (i_out_stall)
    );

    assign o_in_stall = q_full;

`ifndef SYNTHESIS
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_hsv.saturation == '0) |-> (o_hsv.hue == '0))
        else $error("hue not zero for a grey pixel");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_hsv.brightness == '0) |-> (o_hsv.saturation == '0))
        else $error("saturation not zero for a black pixel");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hsv.hue < 15'd23040))
        else $error("hue out of range");
`endif

endmodule
